// ----- design/sfpa_pkg.sv -----
// Shared constants and types of the sensor frame parser and averager.
package sfpa_pkg;

  // Frame header bytes.
  localparam logic [7:0] HDR_BYTE0 = 8'h42;
  localparam logic [7:0] HDR_BYTE1 = 8'h4D;
  localparam logic [7:0] HDR_BYTE2 = 8'hA0;

  // Command that carries a sensor sample, and the data length such a frame has.
  localparam logic [15:0] CMD_SAMPLE   = 16'h0003;
  localparam int          SAMPLE_BYTES = 5;

  // Default number of stored data bytes per frame.
  localparam int PAYLOAD_DEPTH_DEFAULT = 5;

  // Averaging register.
  localparam int         AVG_LOG2_W     = 3;
  localparam logic [2:0] AVG_LOG2_RESET = 3'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_CS_HIGH  = 2'd2;
  localparam logic [1:0] ERR_CS_LOW   = 2'd3;

  typedef struct packed {
    logic        value_valid;
    logic [31:0] avg_value;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ----- design/sensor_frame_parser_averager_core.sv -----
// Frame parser and sample averager: byte-wide input, one result per byte.
//
// Usage: received bytes enter on the input channel (in_valid_i, rx_byte_i,
// in_stall_o); every accepted byte produces exactly one result on the output
// channel (out_valid_o, value_valid_o, avg_value_o, error_code_o, out_stall_i).
// A transfer happens on a rising edge where valid is high and stall is low.
// The parser state and the result are both registered on the edge that accepts
// the byte, the result into the output register or, while that is stalled, into
// the skid register; one byte can be taken every cycle while the skid register
// is empty. The sample adder and the checksum adder are combinational.
// When the receiver stalls, the result in the output register holds and one
// further result is caught in a skid register; only while the skid register
// is full does in_stall_o rise. The averaging register (log2 of the number of
// samples per average) is written over the cfg channel, which is always ready.
// Reset clears the parser to header search, the checksum, the sample sum and
// count, both result valid flags, and sets the averaging register to 2.
module sensor_frame_parser_averager_core #(
  parameter int PAYLOAD_DEPTH = sfpa_pkg::PAYLOAD_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfpa_pkg::AVG_LOG2_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          value_valid_o,
  output logic [31:0]                   avg_value_o,
  output logic [1:0]                    error_code_o
);
  import sfpa_pkg::*;

  localparam int CntW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int IdxW = $clog2(PAYLOAD_DEPTH);

  localparam logic [3:0] ST_HDR0 = 4'd0;
  localparam logic [3:0] ST_HDR1 = 4'd1;
  localparam logic [3:0] ST_INST = 4'd2;
  localparam logic [3:0] ST_CMD0 = 4'd3;
  localparam logic [3:0] ST_CMD1 = 4'd4;
  localparam logic [3:0] ST_LEN0 = 4'd5;
  localparam logic [3:0] ST_LEN1 = 4'd6;
  localparam logic [3:0] ST_DATA = 4'd7;
  localparam logic [3:0] ST_CS0  = 4'd8;
  localparam logic [3:0] ST_CS1  = 4'd9;

  logic [AVG_LOG2_W-1:0] avg_log2_q;
  logic [3:0]            state_q, state_d;
  logic [15:0]           cmd_q, cmd_d;
  logic [15:0]           remain_q, remain_d;
  logic [15:0]           csum_q, csum_d;
  logic [CntW-1:0]       stored_q, stored_d;
  logic [7:0]            store_q [PAYLOAD_DEPTH];
  logic                  store_we;
  logic [31:0]           sum_q, sum_d;
  logic [7:0]            count_q, count_d;
  result_t               res;
  result_t               out_q, skid_q;
  logic                  out_valid_q, skid_valid_q;
  logic                  in_fire, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    logic [31:0] sample;
    logic [31:0] sum_inc;
    logic [7:0]  count_inc;
    logic [15:0] len_full;

    state_d    = state_q;
    cmd_d      = cmd_q;
    remain_d   = remain_q;
    stored_d   = stored_q;
    sum_d      = sum_q;
    count_d    = count_q;
    store_we   = 1'b0;
    res        = '0;
    sample     = {store_q[0], store_q[1], store_q[2], store_q[3]};
    sum_inc    = sum_q + sample;
    count_inc  = count_q + 8'd1;
    len_full   = {remain_q[15:8], rx_byte_i};

    if (state_q == ST_HDR0) begin
      csum_d = {8'd0, rx_byte_i};
    end else if (state_q < ST_CS0) begin
      csum_d = csum_q + {8'd0, rx_byte_i};
    end else begin
      csum_d = csum_q;
    end

    case (state_q)
      ST_HDR0: begin
        if (rx_byte_i == HDR_BYTE0) state_d = ST_HDR1;
      end
      ST_HDR1: state_d = (rx_byte_i == HDR_BYTE1) ? ST_INST : ST_HDR0;
      ST_INST: state_d = (rx_byte_i == HDR_BYTE2) ? ST_CMD0 : ST_HDR0;
      ST_CMD0: begin
        cmd_d   = {rx_byte_i, 8'd0};
        state_d = ST_CMD1;
      end
      ST_CMD1: begin
        cmd_d   = {cmd_q[15:8], rx_byte_i};
        state_d = ST_LEN0;
      end
      ST_LEN0: begin
        remain_d = {rx_byte_i, 8'd0};
        state_d  = ST_LEN1;
      end
      ST_LEN1: begin
        remain_d = len_full;
        stored_d = '0;
        state_d  = (len_full != 16'd0) ? ST_DATA : ST_CS0;
      end
      ST_DATA: begin
        if (stored_q < CntW'(PAYLOAD_DEPTH)) begin
          store_we = 1'b1;
          stored_d = stored_q + CntW'(1);
        end else begin
          res.error_code = ERR_OVERFLOW;
        end
        remain_d = remain_q - 16'd1;
        if (remain_d == 16'd0) state_d = ST_CS0;
      end
      ST_CS0: begin
        if (rx_byte_i != csum_q[15:8]) begin
          res.error_code = ERR_CS_HIGH;
        end else begin
          state_d = ST_CS1;
        end
      end
      ST_CS1: begin
        if (rx_byte_i != csum_q[7:0]) begin
          res.error_code = ERR_CS_LOW;
        end else if (cmd_q == CMD_SAMPLE && stored_q == CntW'(SAMPLE_BYTES) &&
                     store_q[SAMPLE_BYTES-1] == 8'd0) begin
          // Emit the average once the count reaches the configured power of two.
          if (count_inc == (8'd1 << avg_log2_q)) begin
            res.value_valid = 1'b1;
            res.avg_value   = sum_inc >> avg_log2_q;
            sum_d           = '0;
            count_d         = '0;
          end else begin
            sum_d   = sum_inc;
            count_d = count_inc;
          end
        end
        state_d = ST_HDR0;
      end
      default: state_d = ST_HDR0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_log2_q <= AVG_LOG2_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      avg_log2_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HDR0;
      cmd_q    <= '0;
      remain_q <= '0;
      csum_q   <= '0;
      stored_q <= '0;
      sum_q    <= '0;
      count_q  <= '0;
    end else if (in_fire) begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      remain_q <= remain_d;
      csum_q   <= csum_d;
      stored_q <= stored_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && store_we) begin
      store_q[stored_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_valid_o = out_q.value_valid;
  assign avg_value_o   = out_q.avg_value;
  assign error_code_o  = out_q.error_code;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_avg_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.value_valid) |-> (out_q.error_code == ERR_NONE))
    else $error("average emitted together with an error");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= ST_CS1)
    else $error("parser state out of range");

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CntW'(PAYLOAD_DEPTH))
    else $error("stored byte count beyond payload depth");

  a_stall_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");
`endif

endmodule
